>>> hdl/three_axis_moving_average_macros.svh
// ----------------------------------------------------------------------------
// Three-axis moving average: assertion macros
// Immediate-implication and next-cycle-implication checks on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef THREE_AXIS_MOVING_AVERAGE_MACROS_SVH
`define THREE_AXIS_MOVING_AVERAGE_MACROS_SVH

`ifndef SYNTHESIS
`define TAMA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tama assertion failed");
`define TAMA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tama assertion failed");
`else
`define TAMA_ASSERT_NOW(label, ante, cons)
`define TAMA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> hdl/tama_pkg.sv
// ----------------------------------------------------------------------------
// Three-axis moving average package
// Window size, derived widths, payload types, sequencer states.
// ----------------------------------------------------------------------------
package tama_pkg;

  localparam int WINDOW = 100;
  localparam int AXES   = 3;
  localparam int RAW_W  = 16;
  localparam int FRAC_W = 8;
  localparam int MEAN_W = 24;

  localparam int PTR_W  = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = RAW_W + $clog2(WINDOW);
  localparam int DVD_W  = SUM_W + FRAC_W;
  localparam int STEP_W = $clog2(DVD_W + 1);
  localparam int AXIS_W = $clog2(AXES);

  typedef struct packed {
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic signed [RAW_W-1:0] raw_z;
  } in_item_t;

  typedef struct packed {
    logic signed [MEAN_W-1:0] mean_x;
    logic signed [MEAN_W-1:0] mean_y;
    logic signed [MEAN_W-1:0] mean_z;
  } out_item_t;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
    logic [CNT_W-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [MEAN_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUTPUT
  } state_t;

endpackage

>>> hdl/three_axis_moving_average.sv
// The shared serial divider runs three times per sample, one quotient bit per
// cycle; a new sample is taken only once the last one's means are loaded for output.
// A finished result waits in the output register while the next sample is taken.
// Reset (rst_n low, synchronous): sums, pointer and fill count go to zero; ring
// slots not yet written read as zero because the fill count gates the oldest sample.
// ----------------------------------------------------------------------------
// Three-axis moving average
// Boxcar mean over the last WINDOW gyro samples, Q.8 raw counts per axis.
// ----------------------------------------------------------------------------
`include "three_axis_moving_average_macros.svh"

module three_axis_moving_average (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tama_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tama_pkg::out_item_t out_data
);

  tama_pkg::state_t state_r, state_nxt;

  tama_pkg::in_item_t         samp_r, samp_nxt;
  logic signed [tama_pkg::SUM_W-1:0]  sum_r  [tama_pkg::AXES];
  logic signed [tama_pkg::SUM_W-1:0]  sum_nxt [tama_pkg::AXES];
  logic signed [tama_pkg::MEAN_W-1:0] mean_r [tama_pkg::AXES];
  logic signed [tama_pkg::MEAN_W-1:0] mean_nxt [tama_pkg::AXES];
  logic [tama_pkg::CNT_W-1:0]  fill_r, fill_nxt;
  logic [tama_pkg::PTR_W-1:0]  ptr_r, ptr_nxt;
  logic [tama_pkg::AXIS_W-1:0] axis_r, axis_nxt;
  logic                        out_valid_r, out_valid_nxt;
  tama_pkg::out_item_t         out_data_r, out_data_nxt;

  logic                        rd_en;
  logic                        wr_en;
  logic                        out_load;
  tama_pkg::in_item_t          rd_data;
  tama_pkg::div_req_t          div_req;
  tama_pkg::div_rsp_t          div_rsp;

  logic signed [tama_pkg::RAW_W-1:0] new_s [tama_pkg::AXES];
  logic signed [tama_pkg::RAW_W-1:0] old_s [tama_pkg::AXES];
  logic                              full;

  tama_ring u_ring (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (ptr_r),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (ptr_r),
    .wr_data (samp_r)
  );

  tama_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tama_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = tama_pkg::ST_UPDATE;
      end
      tama_pkg::ST_UPDATE: state_nxt = tama_pkg::ST_DIV_GO;
      tama_pkg::ST_DIV_GO: state_nxt = tama_pkg::ST_DIV_WAIT;
      tama_pkg::ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          if (axis_r == tama_pkg::AXIS_W'(tama_pkg::AXES - 1)) begin
            state_nxt = tama_pkg::ST_OUTPUT;
          end else begin
            state_nxt = tama_pkg::ST_DIV_GO;
          end
        end
      end
      tama_pkg::ST_OUTPUT: begin
        if (!out_valid_r || !out_stall) state_nxt = tama_pkg::ST_IDLE;
      end
      default: state_nxt = tama_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall         = (state_r != tama_pkg::ST_IDLE);
    rd_en            = in_valid && (state_r == tama_pkg::ST_IDLE);
    wr_en            = (state_r == tama_pkg::ST_UPDATE);
    out_load         = (state_r == tama_pkg::ST_OUTPUT) && (!out_valid_r || !out_stall);
    div_req.start    = (state_r == tama_pkg::ST_DIV_GO);
    div_req.dividend = sum_r[axis_r];
    div_req.divisor  = fill_r;
  end

  // datapath
  always_comb begin
    new_s[0] = samp_r.raw_x;
    new_s[1] = samp_r.raw_y;
    new_s[2] = samp_r.raw_z;
    // slot at the pointer is unwritten until the window has filled once
    full     = (fill_r == tama_pkg::CNT_W'(tama_pkg::WINDOW));
    old_s[0] = full ? rd_data.raw_x : '0;
    old_s[1] = full ? rd_data.raw_y : '0;
    old_s[2] = full ? rd_data.raw_z : '0;

    samp_nxt      = samp_r;
    fill_nxt      = fill_r;
    ptr_nxt       = ptr_r;
    axis_nxt      = axis_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    for (int a = 0; a < tama_pkg::AXES; a++) begin
      sum_nxt[a]  = sum_r[a];
      mean_nxt[a] = mean_r[a];
    end

    if (rd_en) samp_nxt = in_data;

    if (wr_en) begin
      for (int a = 0; a < tama_pkg::AXES; a++) begin
        sum_nxt[a] = sum_r[a] - tama_pkg::SUM_W'(old_s[a]) + tama_pkg::SUM_W'(new_s[a]);
      end
      if (!full) fill_nxt = fill_r + 1'b1;
      ptr_nxt  = (ptr_r == tama_pkg::PTR_W'(tama_pkg::WINDOW - 1)) ? '0 : ptr_r + 1'b1;
      axis_nxt = '0;
    end

    if ((state_r == tama_pkg::ST_DIV_WAIT) && div_rsp.done) begin
      mean_nxt[axis_r] = div_rsp.quotient;
      axis_nxt         = axis_r + 1'b1;
    end

    if (out_load) begin
      out_valid_nxt       = 1'b1;
      out_data_nxt.mean_x = mean_r[0];
      out_data_nxt.mean_y = mean_r[1];
      out_data_nxt.mean_z = mean_r[2];
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tama_pkg::ST_IDLE;
      fill_r      <= '0;
      ptr_r       <= '0;
      axis_r      <= '0;
      out_valid_r <= 1'b0;
      for (int a = 0; a < tama_pkg::AXES; a++) begin
        sum_r[a] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      ptr_r       <= ptr_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
      for (int a = 0; a < tama_pkg::AXES; a++) begin
        sum_r[a] <= sum_nxt[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    samp_r     <= samp_nxt;
    out_data_r <= out_data_nxt;
    for (int a = 0; a < tama_pkg::AXES; a++) begin
      mean_r[a] <= mean_nxt[a];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `TAMA_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= tama_pkg::CNT_W'(tama_pkg::WINDOW))
  `TAMA_ASSERT_NOW(a_ptr_bound, 1'b1, ptr_r <= tama_pkg::PTR_W'(tama_pkg::WINDOW - 1))
  `TAMA_ASSERT_NOW(a_div_done_wait, div_rsp.done, state_r == tama_pkg::ST_DIV_WAIT)
  `TAMA_ASSERT_NEXT(a_out_load, out_load, out_valid_r && (state_r == tama_pkg::ST_IDLE))

endmodule

>>> hdl/tama_ring.sv
// ----------------------------------------------------------------------------
// Sample ring
// One-write, one-read memory of the last WINDOW samples, registered read.
// ----------------------------------------------------------------------------
module tama_ring (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [tama_pkg::PTR_W-1:0] rd_addr,
  output tama_pkg::in_item_t         rd_data,
  input  logic                       wr_en,
  input  logic [tama_pkg::PTR_W-1:0] wr_addr,
  input  tama_pkg::in_item_t         wr_data
);

  tama_pkg::in_item_t mem [tama_pkg::WINDOW];
  tama_pkg::in_item_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/tama_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Signed (dividend * 2^FRAC_W) / unsigned divisor, one quotient bit per cycle,
// truncated toward zero.
// ----------------------------------------------------------------------------
module tama_div (
  input  logic               clk,
  input  logic               rst_n,
  input  tama_pkg::div_req_t req,
  output tama_pkg::div_rsp_t rsp
);

  logic                        busy_r, busy_nxt;
  logic                        fin_r, fin_nxt;
  logic [tama_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic [tama_pkg::DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [tama_pkg::CNT_W-1:0]  rem_r, rem_nxt;
  logic [tama_pkg::CNT_W-1:0]  dsr_r, dsr_nxt;
  logic                        neg_r, neg_nxt;

  logic [tama_pkg::SUM_W-1:0]  mag;
  logic [tama_pkg::CNT_W:0]    rem_sh;
  logic [tama_pkg::CNT_W:0]    rem_sub;
  logic                        ge;
  logic [tama_pkg::DVD_W-1:0]  quo_mag;

  always_comb begin
    mag     = req.dividend[tama_pkg::SUM_W-1] ? tama_pkg::SUM_W'(-req.dividend)
                                              : tama_pkg::SUM_W'(req.dividend);
    rem_sh  = {rem_r, dvd_r[tama_pkg::DVD_W-1]};
    rem_sub = rem_sh - {1'b0, dsr_r};
    ge      = (rem_sh >= {1'b0, dsr_r});

    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    neg_nxt  = neg_r;

    if (busy_r) begin
      rem_nxt = ge ? rem_sub[tama_pkg::CNT_W-1:0] : rem_sh[tama_pkg::CNT_W-1:0];
      dvd_nxt = {dvd_r[tama_pkg::DVD_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == tama_pkg::STEP_W'(tama_pkg::DVD_W - 1)) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = {mag, tama_pkg::FRAC_W'(0)};
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
      neg_nxt  = req.dividend[tama_pkg::SUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    neg_r <= neg_nxt;
  end

  // dvd_r holds the quotient magnitude once the last step is done
  assign quo_mag      = neg_r ? (~dvd_r + 1'b1) : dvd_r;
  assign rsp.done     = fin_r;
  assign rsp.quotient = quo_mag[tama_pkg::MEAN_W-1:0];

endmodule

>>> verif/three_axis_moving_average_tb.sv
// ----------------------------------------------------------------------------
// Three-axis moving average testbench
// Streams gyro samples through the boxcar filter under random handshake
// idling and checks every Q.8 axis mean against a cycle-free predictor.
// ----------------------------------------------------------------------------
module three_axis_moving_average_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 1350;
  localparam int SETTLE      = 3 * (tama_pkg::DVD_W + 2) + 2 + 40;
  localparam int CYCLE_LIMIT = 1000000;

  typedef enum int {
    SEG_NOISE,
    SEG_RAIL,
    SEG_SMALL,
    SEG_NEAR_RAIL,
    SEG_ALTERNATE
  } segment_kind_t;

  typedef struct {
    tama_pkg::in_item_t sample;
    bit                 drain;    // hold off until every mean is back
  } pending_sample_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  tama_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  tama_pkg::out_item_t out_data;

  pending_sample_t     samples_pending[$];
  tama_pkg::out_item_t means_due[$];

  int item_total = 0;
  int samples_taken = 0;
  int means_checked = 0;
  int errors = 0;
  int cycle_count = 0;
  int sender_idle_pct;
  int stall_pct;

  // predictor state
  tama_pkg::in_item_t window_ring [tama_pkg::WINDOW];
  int                 sum_x = 0;
  int                 sum_y = 0;
  int                 sum_z = 0;
  int                 ring_slot = 0;
  int                 fill = 0;

  three_axis_moving_average uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic signed [tama_pkg::MEAN_W-1:0] q8_mean(int sum);
    longint q;
    q = (longint'(sum) * 256) / longint'(fill);   // truncates toward zero
    return q[tama_pkg::MEAN_W-1:0];
  endfunction

  function automatic tama_pkg::out_item_t boxcar_update(tama_pkg::in_item_t s);
    tama_pkg::in_item_t  oldest;
    tama_pkg::out_item_t m;
    oldest = window_ring[ring_slot];
    if (fill < tama_pkg::WINDOW) fill++;
    sum_x = sum_x - oldest.raw_x + s.raw_x;
    sum_y = sum_y - oldest.raw_y + s.raw_y;
    sum_z = sum_z - oldest.raw_z + s.raw_z;
    window_ring[ring_slot] = s;
    ring_slot = (ring_slot + 1 == tama_pkg::WINDOW) ? 0 : ring_slot + 1;
    m.mean_x = q8_mean(sum_x);
    m.mean_y = q8_mean(sum_y);
    m.mean_z = q8_mean(sum_z);
    return m;
  endfunction

  function automatic logic signed [tama_pkg::RAW_W-1:0] rail_pick();
    return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
  endfunction

  task automatic queue_sample(input logic signed [tama_pkg::RAW_W-1:0] x, y, z);
    pending_sample_t p;
    p.sample.raw_x = x;
    p.sample.raw_y = y;
    p.sample.raw_z = z;
    p.drain = ($urandom_range(199) == 0);
    samples_pending.push_back(p);
  endtask

  // idle mix by run phase: sender-light, receiver-light, then none
  always_comb begin
    if (samples_taken < item_total / 3) begin
      sender_idle_pct = 29;
      stall_pct = 56;
    end else if (samples_taken < (2 * item_total) / 3) begin
      sender_idle_pct = 56;
      stall_pct = 29;
    end else begin
      sender_idle_pct = 0;
      stall_pct = 0;
    end
  end

  always @(posedge clk) begin : drive_samples
    pending_sample_t nxt;
    bit              holding;
    bit              gap;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      holding = in_valid && in_stall;
      if (in_valid && !in_stall) begin
        means_due.push_back(boxcar_update(in_data));
        samples_taken <= samples_taken + 1;
      end
      if (!holding) begin
        gap = (samples_pending.size() == 0) || ($urandom_range(99) < sender_idle_pct);
        if (!gap && samples_pending[0].drain && means_due.size() != 0) gap = 1'b1;
        if (gap) begin
          in_valid <= 1'b0;
        end else begin
          nxt = samples_pending.pop_front();
          in_valid <= 1'b1;
          in_data <= nxt.sample;
        end
      end
    end
  end

  always @(posedge clk) begin : check_means
    tama_pkg::out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (means_due.size() == 0) begin
          errors++;
          $error("unexpected transaction: mean_x %0d mean_y %0d mean_z %0d",
                 out_data.mean_x, out_data.mean_y, out_data.mean_z);
        end else begin
          want = means_due.pop_front();
          means_checked++;
          if (out_data.mean_x !== want.mean_x) begin
            errors++;
            $error("mean_x mismatch: expected %0d, actual %0d", want.mean_x, out_data.mean_x);
          end
          if (out_data.mean_y !== want.mean_y) begin
            errors++;
            $error("mean_y mismatch: expected %0d, actual %0d", want.mean_y, out_data.mean_y);
          end
          if (out_data.mean_z !== want.mean_z) begin
            errors++;
            $error("mean_z mismatch: expected %0d, actual %0d", want.mean_z, out_data.mean_z);
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d samples taken", cycle_count, samples_taken);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    segment_kind_t                     seg;
    int                                run;
    logic signed [tama_pkg::RAW_W-1:0] rx, ry, rz;
    logic signed [tama_pkg::RAW_W-1:0] vx, vy, vz;

    foreach (window_ring[i]) window_ring[i] = '0;

    // directed: rails, mixed signs, bit patterns, small values for truncation
    queue_sample(0, 0, 0);
    queue_sample(32767, 32767, 32767);
    queue_sample(-32768, -32768, -32768);
    queue_sample(32767, -32768, 0);
    queue_sample(-32768, 0, 32767);
    queue_sample(0, 32767, -32768);
    queue_sample(-1, -1, -1);
    queue_sample(1, -1, 1);
    queue_sample(16'sh5555, 16'shAAAA, 16'sh00FF);
    queue_sample(16'shAAAA, 16'sh5555, 16'shFF00);
    queue_sample(-3, 5, -7);
    queue_sample(7, -7, 2);
    queue_sample(1, 0, -1);
    queue_sample(-32767, 32766, -2);
    queue_sample(16'sh8001, 16'sh7FFE, 16'sh0001);
    queue_sample(-32768, -32768, -32768);
    queue_sample(-32768, -32768, -32768);
    queue_sample(32767, 32767, 32767);
    queue_sample(100, -100, 33);
    queue_sample(0, 0, 0);

    // random: segments of different character; rail runs at least as long as the
    // window drive the sums to their limits and wrap the ring
    while (samples_pending.size() < ITEM_TARGET) begin
      seg = segment_kind_t'($urandom_range(9) < 4 ? SEG_NOISE :
                            $urandom_range(4));
      case (seg)
        SEG_RAIL:  run = tama_pkg::WINDOW + $urandom_range(40);
        SEG_NOISE: run = $urandom_range(1, 40);
        default:   run = $urandom_range(10, 60);
      endcase
      if (run > ITEM_TARGET - samples_pending.size()) run = ITEM_TARGET - samples_pending.size();
      rx = rail_pick();
      ry = rail_pick();
      rz = rail_pick();
      for (int i = 0; i < run; i++) begin
        case (seg)
          SEG_RAIL: begin
            vx = rx;
            vy = ry;
            vz = rz;
          end
          SEG_SMALL: begin
            vx = tama_pkg::RAW_W'($urandom_range(600) - 300);
            vy = tama_pkg::RAW_W'($urandom_range(600) - 300);
            vz = tama_pkg::RAW_W'($urandom_range(600) - 300);
          end
          SEG_NEAR_RAIL: begin
            vx = rx ^ tama_pkg::RAW_W'($urandom_range(255));
            vy = ry ^ tama_pkg::RAW_W'($urandom_range(255));
            vz = rz ^ tama_pkg::RAW_W'($urandom_range(255));
          end
          SEG_ALTERNATE: begin
            vx = (i % 2) ? rx : ~rx;
            vy = (i % 2) ? ry : ~ry;
            vz = (i % 2) ? rz : ~rz;
          end
          default: begin
            vx = tama_pkg::RAW_W'($urandom_range(16'hFFFF));
            vy = tama_pkg::RAW_W'($urandom_range(16'hFFFF));
            vz = tama_pkg::RAW_W'($urandom_range(16'hFFFF));
          end
        endcase
        queue_sample(vx, vy, vz);
      end
    end

    item_total = samples_pending.size();
    // force a full drain at each change of idle mix
    samples_pending[item_total / 3].drain = 1'b1;
    samples_pending[(2 * item_total) / 3].drain = 1'b1;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (samples_taken != item_total || means_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (means_due.size() != 0) begin
      errors++;
      $error("%0d means never arrived", means_due.size());
    end

    $display("Ran %0d samples through the %0d-deep window (%0d ring wraps), rails and noise,",
             samples_taken, tama_pkg::WINDOW, samples_taken / tama_pkg::WINDOW);
    $display("under three idle mixes; %0d means checked, %0d errors.", means_checked, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
